>>> hdl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LSW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");

// antecedent followed in the next cycle by consequent
`define LSW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hdl/lsw_pkg.sv
// shared types and constants of the light switch controller
package lsw_pkg;

	localparam int unsigned SECONDS_W = 16;
	localparam int unsigned TIMEOUT_MS_W = 26;
	localparam int unsigned TIME_W = 32;
	localparam logic [9:0] MS_PER_SECOND = 10'd1000;

	localparam logic [2:0] OP_POLL = 3'd0;
	localparam logic [2:0] OP_SET_ENABLE = 3'd1;
	localparam logic [2:0] OP_REMOTE_ON = 3'd2;
	localparam logic [2:0] OP_REMOTE_OFF = 3'd3;
	localparam logic [2:0] OP_UNKNOWN = 3'd4;

	localparam logic REG_TOGGLE_MODE = 1'b0;
	localparam logic REG_AUTO_OFF_SECONDS = 1'b1;

	typedef struct packed {
		logic [2:0] op;
		logic button_pressed;
		logic button_held;
		logic [TIME_W-1:0] now_ms;
		logic enable_value;
	} in_t;

	typedef struct packed {
		logic light_on;
		logic command_accepted;
	} out_t;

	typedef struct packed {
		logic toggle_mode;
		logic [TIMEOUT_MS_W-1:0] auto_off_ms;
	} cfg_t;

endpackage

>>> hdl/light_switch_with_auto_off_core.sv
// top level of the light switch controller with auto-off timer
// path: a taken request waits in the input register, and its result is held in the result register
// throughput: one request per cycle unless a result stalls; state is updated between the input and result registers
// while a result is stalled the empty input register takes one more request, then in_ready drops
// reset: asynchronous, active low; light off, disabled, timer cleared, toggle mode on
module light_switch_with_auto_off_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input lsw_pkg::in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output lsw_pkg::out_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import lsw_pkg::*;

	logic s1_valid_q;
	in_t item_s1;
	logic out_valid_q;
	out_t out_data_q;
	logic advance, step;
	cfg_t cfg;
	out_t result;

	assign pready = 1'b1;

	lsw_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	assign advance = !out_valid_q || out_ready;
	assign step = s1_valid_q && advance;
	assign in_ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_ready)
			s1_valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
	end

	lsw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(item_s1),
		.cfg(cfg),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= s1_valid_q;
	end

	always_ff @(posedge clk) begin
		if (step)
			out_data_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

>>> hdl/lsw_regs.sv
// configuration registers behind the apb port
module lsw_regs (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output lsw_pkg::cfg_t cfg
);
	import lsw_pkg::*;

	logic toggle_mode_q;
	logic [SECONDS_W-1:0] auto_off_seconds_q;
	logic [TIMEOUT_MS_W-1:0] auto_off_ms_q;
	logic wr_en;

	assign wr_en = psel && penable && pwrite;

	// millisecond limit is worked out once, at the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_mode_q <= 1'b1;
			auto_off_seconds_q <= '0;
			auto_off_ms_q <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				REG_TOGGLE_MODE: toggle_mode_q <= pwdata[0];
				REG_AUTO_OFF_SECONDS: begin
					auto_off_seconds_q <= pwdata[SECONDS_W-1:0];
					auto_off_ms_q <= TIMEOUT_MS_W'(pwdata[SECONDS_W-1:0])
						* TIMEOUT_MS_W'(MS_PER_SECOND);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_TOGGLE_MODE: prdata = {31'b0, toggle_mode_q};
			REG_AUTO_OFF_SECONDS: prdata = {16'b0, auto_off_seconds_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.toggle_mode = toggle_mode_q;
	assign cfg.auto_off_ms = auto_off_ms_q;

endmodule

>>> hdl/lsw_ctrl.sv
// light state, edge memory and auto-off timer
module lsw_ctrl (
	input logic clk,
	input logic arst_n,
	input logic step,
	input lsw_pkg::in_t item,
	input lsw_pkg::cfg_t cfg,
	output lsw_pkg::out_t result
);
	import lsw_pkg::*;

	logic enabled_q, light_q, last_pressed_q;
	logic [TIMEOUT_MS_W-1:0] timeout_ms_q;
	logic [TIME_W-1:0] on_stamp_q;

	logic enabled_n, light_n, last_pressed_n, accepted;
	logic [TIMEOUT_MS_W-1:0] timeout_ms_n;
	logic [TIME_W-1:0] on_stamp_n;
	logic [TIME_W-1:0] elapsed;

	assign elapsed = item.now_ms - on_stamp_q;

	always_comb begin
		enabled_n = enabled_q;
		light_n = light_q;
		last_pressed_n = last_pressed_q;
		timeout_ms_n = timeout_ms_q;
		on_stamp_n = on_stamp_q;
		accepted = 1'b0;
		case (item.op)
			OP_POLL: begin
				if (enabled_q) begin
					if (last_pressed_q != item.button_pressed) begin
						last_pressed_n = item.button_pressed;
						if (cfg.toggle_mode) begin
							if (item.button_pressed) begin
								if (light_q) begin
									light_n = 1'b0;
								end else begin
									on_stamp_n = item.now_ms;
									timeout_ms_n = cfg.auto_off_ms;
									light_n = 1'b1;
								end
							end
						end else begin
							timeout_ms_n = '0;
							light_n = item.button_pressed;
						end
					end else if (timeout_ms_q != '0) begin
						// holding the button cancels the running timer
						if (item.button_held) begin
							timeout_ms_n = '0;
						end else if (light_q &&
							elapsed >= TIME_W'(timeout_ms_q)) begin
							light_n = 1'b0;
						end
					end
				end
			end
			OP_SET_ENABLE: begin
				if (enabled_q && !item.enable_value)
					light_n = 1'b0;
				enabled_n = item.enable_value;
				last_pressed_n = 1'b0;
			end
			OP_REMOTE_ON: begin
				timeout_ms_n = '0;
				if (enabled_q)
					light_n = 1'b1;
				accepted = 1'b1;
			end
			OP_REMOTE_OFF: begin
				if (enabled_q)
					light_n = 1'b0;
				accepted = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			light_q <= 1'b0;
			last_pressed_q <= 1'b0;
			timeout_ms_q <= '0;
			on_stamp_q <= '0;
		end else if (step) begin
			enabled_q <= enabled_n;
			light_q <= light_n;
			last_pressed_q <= last_pressed_n;
			timeout_ms_q <= timeout_ms_n;
			on_stamp_q <= on_stamp_n;
		end
	end

	assign result.light_on = light_n;
	assign result.command_accepted = accepted;

endmodule

>>> hdl/lsw_checker.sv
// port-level checks of the light switch controller
`include "assert_macros.svh"

module lsw_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input lsw_pkg::in_t in_data,
	input logic out_valid,
	input logic out_ready,
	input lsw_pkg::out_t out_data
);
	import lsw_pkg::*;

	logic in_fire, in_remote;

	assign in_fire = in_valid && in_ready;
	assign in_remote = in_data.op == OP_REMOTE_ON || in_data.op == OP_REMOTE_OFF;

	// a stalled result stays put
	`LSW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// a free output side never blocks requests
	`LSW_ASSERT(a_ready_when_drained, !out_ready || in_ready)
	// a request reaches the output through the input register when the sink keeps up
	`LSW_ASSERT_NEXT(a_latency, $past(in_fire) && out_ready, out_valid)
	// remote commands are acknowledged in their result
	`LSW_ASSERT_NEXT(a_remote_ack, $past(in_fire && in_remote) && out_ready,
		out_data.command_accepted)

endmodule

bind light_switch_with_auto_off_core lsw_checker u_lsw_checker (.*);

>>> sim/light_switch_with_auto_off_core_test.sv
// self-checking testbench for the light switch controller with auto-off timer
`timescale 1ns / 1ps

module light_switch_with_auto_off_core_test;
	import lsw_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	light_switch_with_auto_off_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	in_t request_q[$];
	out_t relay_expect_q[$];
	int errors = 0;
	bit idling_on = 1'b1;
	int src_idle = 0;
	int sink_idle = 0;
	int stall_cycles = 0;

	// register mirror and controller state
	logic cfg_toggle = 1'b1;
	logic [15:0] cfg_secs = '0;
	logic sw_enabled = 1'b0;
	logic sw_light = 1'b0;
	logic sw_last_press = 1'b0;
	logic [15:0] sw_timeout_s = '0;
	logic [31:0] sw_on_stamp = '0;

	logic gen_pressed = 1'b0;
	logic [31:0] gen_now = '0;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic light_predict(input in_t req);
		out_t res;
		logic [31:0] elapsed;
		res.command_accepted = 1'b0;
		elapsed = req.now_ms - sw_on_stamp;
		case (req.op)
			OP_POLL: begin
				if (sw_enabled) begin
					if (sw_last_press != req.button_pressed) begin
						sw_last_press = req.button_pressed;
						if (cfg_toggle) begin
							if (req.button_pressed) begin
								if (sw_light) begin
									sw_light = 1'b0;
								end else begin
									sw_on_stamp = req.now_ms;
									sw_timeout_s = cfg_secs;
									sw_light = 1'b1;
								end
							end
						end else begin
							sw_timeout_s = '0;
							sw_light = req.button_pressed;
						end
					end else if (sw_timeout_s != 0) begin
						if (req.button_held) begin
							sw_timeout_s = '0;
						end else if (sw_light &&
								elapsed >= 32'(sw_timeout_s) * 32'(MS_PER_SECOND)) begin
							sw_light = 1'b0;
						end
					end
				end
			end
			OP_SET_ENABLE: begin
				if (sw_enabled && !req.enable_value)
					sw_light = 1'b0;
				sw_enabled = req.enable_value;
				sw_last_press = 1'b0;
			end
			OP_REMOTE_ON: begin
				sw_timeout_s = '0;
				if (sw_enabled)
					sw_light = 1'b1;
				res.command_accepted = 1'b1;
			end
			OP_REMOTE_OFF: begin
				if (sw_enabled)
					sw_light = 1'b0;
				res.command_accepted = 1'b1;
			end
			default: ;
		endcase
		res.light_on = sw_light;
		relay_expect_q.push_back(res);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			src_idle <= 0;
		end else begin
			if (in_valid && in_ready)
				light_predict(in_data);
			if (!in_valid || in_ready) begin
				if (src_idle > 0) begin
					in_valid <= 1'b0;
					src_idle <= src_idle - 1;
				end else if (request_q.size() == 0) begin
					in_valid <= 1'b0;
				end else if (idling_on && $urandom_range(0, 11) == 0) begin
					in_valid <= 1'b0;
					src_idle <= $urandom_range(0, 11);
				end else begin
					in_data <= request_q.pop_front();
					in_valid <= 1'b1;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_idle <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (relay_expect_q.size() == 0) begin
					$error("result with no request pending: light_on %0d command_accepted %0d",
						out_data.light_on, out_data.command_accepted);
					errors++;
				end else begin
					want = relay_expect_q.pop_front();
					if (out_data.light_on !== want.light_on) begin
						$error("light_on expected %0d got %0d", want.light_on, out_data.light_on);
						errors++;
					end
					if (out_data.command_accepted !== want.command_accepted) begin
						$error("command_accepted expected %0d got %0d",
							want.command_accepted, out_data.command_accepted);
						errors++;
					end
				end
			end
			if (sink_idle > 0) begin
				out_ready <= 1'b0;
				sink_idle <= sink_idle - 1;
			end else if (idling_on && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				sink_idle <= $urandom_range(0, 11);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on handshake progress
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic in_t req_of(logic [2:0] op, logic pr, logic hd, logic [31:0] t, logic en);
		in_t r;
		r.op = op;
		r.button_pressed = pr;
		r.button_held = hd;
		r.now_ms = t;
		r.enable_value = en;
		return r;
	endfunction

	task automatic reg_write(input logic idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_TOGGLE_MODE)
			cfg_toggle = val[0];
		else
			cfg_secs = val[15:0];
	endtask

	// wait until every request has been answered
	task automatic settle();
		while (request_q.size() != 0 || in_valid || relay_expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic push_random(input int n);
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 62) begin
				if ($urandom_range(0, 4) == 0)
					gen_pressed = ~gen_pressed;
				if ($urandom_range(0, 19) == 0)
					gen_now = $urandom;
				else
					gen_now = gen_now + $urandom_range(0, 800);
				request_q.push_back(req_of(OP_POLL, gen_pressed, $urandom_range(0, 7) == 0,
					gen_now, 1'($urandom_range(0, 1))));
			end else if (r < 70) begin
				request_q.push_back(req_of(OP_SET_ENABLE, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom, $urandom_range(0, 4) != 0));
			end else if (r < 78) begin
				request_q.push_back(req_of(OP_REMOTE_ON, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1))));
			end else if (r < 86) begin
				request_q.push_back(req_of(OP_REMOTE_OFF, 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1))));
			end else if (r < 90) begin
				request_q.push_back(req_of(OP_UNKNOWN + 3'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
					1'($urandom_range(0, 1))));
			end else begin
				// noise: any opcode, any field values
				request_q.push_back(req_of(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1))));
			end
		end
	endtask

	task automatic run_phase(input logic tog, input logic [15:0] secs, input int n,
			input bit with_idle);
		settle();
		reg_write(REG_TOGGLE_MODE, {31'd0, tog});
		reg_write(REG_AUTO_OFF_SECONDS, {16'd0, secs});
		idling_on = with_idle;
		push_random(n);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: disabled block, then plain toggling without timer
		request_q.push_back(req_of(OP_POLL, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
		request_q.push_back(req_of(OP_REMOTE_ON, 1'b0, 1'b0, '0, 1'b0));
		request_q.push_back(req_of(OP_REMOTE_OFF, 1'b0, 1'b0, '0, 1'b0));
		for (int k = 0; k < 4; k++)
			request_q.push_back(req_of(OP_UNKNOWN + 3'(k), 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
		request_q.push_back(req_of(OP_SET_ENABLE, 1'b0, 1'b0, '0, 1'b1));
		request_q.push_back(req_of(OP_POLL, 1'b1, 1'b0, '0, 1'b0));
		request_q.push_back(req_of(OP_POLL, 1'b0, 1'b0, 32'd10, 1'b0));
		request_q.push_back(req_of(OP_POLL, 1'b1, 1'b0, 32'd20, 1'b0));
		request_q.push_back(req_of(OP_REMOTE_ON, 1'b0, 1'b0, '0, 1'b0));
		request_q.push_back(req_of(OP_SET_ENABLE, 1'b0, 1'b0, '0, 1'b0));
		request_q.push_back(req_of(OP_SET_ENABLE, 1'b0, 1'b0, '0, 1'b0));
		request_q.push_back(req_of(OP_SET_ENABLE, 1'b0, 1'b0, '0, 1'b1));
		request_q.push_back(req_of(OP_REMOTE_OFF, 1'b0, 1'b0, '0, 1'b0));
		settle();

		// one second timer across the time wrap, then a hold cancelling it
		reg_write(REG_AUTO_OFF_SECONDS, 32'd1);
		request_q.push_back(req_of(OP_POLL, 1'b1, 1'b0, 32'hFFFF_FF00, 1'b0));
		request_q.push_back(req_of(OP_POLL, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0));
		request_q.push_back(req_of(OP_POLL, 1'b0, 1'b0, 32'h0000_02E7, 1'b0));
		request_q.push_back(req_of(OP_POLL, 1'b0, 1'b0, 32'h0000_02E8, 1'b0));
		request_q.push_back(req_of(OP_POLL, 1'b1, 1'b0, '0, 1'b0));
		request_q.push_back(req_of(OP_POLL, 1'b1, 1'b1, 32'd5, 1'b0));
		request_q.push_back(req_of(OP_POLL, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0));

		run_phase(1'b1, 16'd1, 230, 1'b1);
		run_phase(1'b0, 16'd3, 230, 1'b1);
		run_phase(1'b1, 16'hFFFF, 230, 1'b0);
		run_phase(1'b1, 16'd0, 230, 1'b1);
		run_phase(1'b0, 16'd0, 230, 1'b1);
		run_phase(1'b1, 16'd2, 230, 1'b1);
		run_phase(1'b1, 16'($urandom_range(1, 4)), 230, 1'b0);

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> files.f
+incdir+hdl
hdl/lsw_pkg.sv
hdl/lsw_regs.sv
hdl/lsw_ctrl.sv
hdl/light_switch_with_auto_off_core.sv
hdl/lsw_checker.sv
sim/light_switch_with_auto_off_core_test.sv
